### rtl/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// Shared types, constants and helpers for the animated level bar engine.
// ----------------------------------------------------------------------------
package lba_pkg;

  // Width of the internal signed Q16.16 level registers.
  localparam int LW = 32;

  // Divider geometry: a level step divides a (LW+1) x 16 product by a 16-bit
  // duration, a ratio divides (level << 16) by the 32-bit full scale.
  localparam int QW    = LW + 1;
  localparam int DW    = QW + 16;
  localparam int RATIO_BITS = 16;
  localparam int CNTW  = $clog2(QW + 1);

  localparam logic [16:0] RATIO_ONE     = 17'd65536;
  localparam logic [16:0] RATIO_QUARTER = 17'd16384;
  localparam logic [16:0] RATIO_HALF    = 17'd32768;
  localparam logic [15:0] DEFAULT_LAG   = 16'd280;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] STYLE_FLAT  = 2'd0;
  localparam logic [1:0] STYLE_RAMP  = 2'd1;
  localparam logic [1:0] STYLE_TRAIL = 2'd2;
  localparam logic [1:0] STYLE_SEGS  = 2'd3;

  localparam int CFG_AW = 4;
  localparam logic [CFG_AW-1:0] REG_BAR_STYLE   = 4'd0;
  localparam logic [CFG_AW-1:0] REG_ANIM_DUR    = 4'd1;
  localparam logic [CFG_AW-1:0] REG_TRAIL_LAG   = 4'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_LEVEL   = 4'd3;
  localparam logic [CFG_AW-1:0] REG_BASE_COLOR  = 4'd4;
  localparam logic [CFG_AW-1:0] REG_LOW_COLOR   = 4'd5;
  localparam logic [CFG_AW-1:0] REG_MID_COLOR   = 4'd6;
  localparam logic [CFG_AW-1:0] REG_HIGH_COLOR  = 4'd7;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] new_level;
    logic [15:0]        tick_ms;
  } in_item_t;

  typedef struct packed {
    logic [16:0] fill_ratio;
    logic [16:0] trail_ratio;
    logic [31:0] fill_color;
  } out_item_t;

  // Divider request: a load strobe and the choice of a short (ratio) divide.
  typedef struct packed {
    logic go;
    logic short_mode;
  } div_ctl_t;

  // Saturate a 32-bit level into the signed LW-bit range.
  function automatic logic signed [LW-1:0] fit_level(input logic signed [31:0] v);
    logic signed [63:0] w;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [63:0] r;
    w  = {{32{v[31]}}, v};
    hi = (64'sd1 <<< (LW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (w > hi) r = hi;
    else if (w < lo) r = lo;
    else r = w;
    return r[LW-1:0];
  endfunction

endpackage

### rtl/lba_div.sv
// ----------------------------------------------------------------------------
// lba_div
// Restoring divider, one quotient bit per cycle. A long divide produces QW
// quotient bits, a short one RATIO_BITS; the caller guarantees the quotient
// fits. done pulses for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module lba_div import lba_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  div_ctl_t      ctl,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  logic [CNTW-1:0] cnt;
  logic [31:0]     rem;
  logic [DW-1:0]   dq;
  logic [32:0]     trial;
  logic            ge;
  logic [31:0]     rem_next;
  logic [31:0]     rem_init;
  logic [DW-1:0]   dq_init;

  // The upper dividend bits already sit below the divisor, so they seed the
  // remainder and only the low bits are shifted through.
  always_comb begin
    if (ctl.short_mode) begin
      rem_init = 32'(dividend >> RATIO_BITS);
      dq_init  = dividend << (DW - RATIO_BITS);
    end else begin
      rem_init = 32'(dividend >> QW);
      dq_init  = dividend << (DW - QW);
    end
  end

  assign trial    = {rem, dq[DW-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign rem_next = ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
  assign quotient = dq[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        cnt <= ctl.short_mode ? CNTW'(RATIO_BITS) : CNTW'(QW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      rem <= rem_init;
      dq  <= dq_init;
    end else if (cnt != '0) begin
      rem <= rem_next;
      dq  <= {dq[DW-2:0], ge};
    end
  end

endmodule

### rtl/level_bar_animator_with_trail.sv
// ----------------------------------------------------------------------------
// level_bar_animator_with_trail
// Animated level bar with a decaying trail marker and a three-step color ramp.
// ----------------------------------------------------------------------------
// Each input word is either a new target level or a time tick, and each one
// returns exactly one output word with the fill ratio, the trail ratio and the
// fill color after the update. Words are processed one at a time by a small
// sequencer around a single multiplier and a shared one-bit-per-cycle divider.
// A level step that is not a snap (animation or trail decay) takes a registered
// multiply and a 33-bit divide; each ratio that is not trivially zero or full
// scale takes a 16-bit divide. The sequencer returns to idle before the next
// input word is taken, and the result waits in the last state for as long as
// the output register is still full. in_ready is low while an item is in
// flight; a finished word waits in the output register without blocking the
// next input word.
module level_bar_animator_with_trail import lba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_ADIV  = 4'd2;
  localparam logic [3:0] S_TRAIL = 4'd3;
  localparam logic [3:0] S_TDIV  = 4'd4;
  localparam logic [3:0] S_FR    = 4'd5;
  localparam logic [3:0] S_FDIV  = 4'd6;
  localparam logic [3:0] S_TR    = 4'd7;
  localparam logic [3:0] S_RDIV  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Configuration registers.
  logic [1:0]         bar_style;
  logic [15:0]        animate_duration;
  logic [15:0]        trail_lag;
  logic signed [31:0] max_level;
  logic [31:0]        base_color;
  logic [31:0]        low_color;
  logic [31:0]        mid_color;
  logic [31:0]        high_color;

  // Bar state.
  logic signed [LW-1:0] shown_level;
  logic signed [LW-1:0] goal_level;
  logic signed [LW-1:0] trail_level;
  logic [31:0]          anim_elapsed;

  // Sequencer and working registers.
  logic [3:0]           state;
  logic                 cmd;
  logic signed [LW-1:0] lvl;
  logic [15:0]          dt;
  logic                 gap_neg;
  logic [DW-1:0]        prod;
  logic [16:0]          fr;
  logic [16:0]          tr;
  logic                 div_go;

  // Datapath.
  logic signed [LW:0]   gap;
  logic [LW:0]          mag;
  logic [LW:0]          span;
  logic [32:0]          el_sum;
  logic [31:0]          el_sat;
  logic [15:0]          lag_eff;
  logic [DW-1:0]        mul_out;
  logic [LW:0]          mul_a;
  logic [15:0]          mul_b;
  logic [LW:0]          shown_ext;
  logic [LW:0]          trail_ext;
  logic [31:0]          color;

  div_ctl_t             div_ctl;
  logic [DW-1:0]        div_dividend;
  logic [31:0]          div_divisor;
  logic                 div_done;
  logic [QW-1:0]        div_q;

  assign in_ready  = (state == S_IDLE);
  assign gap       = {goal_level[LW-1], goal_level} - {shown_level[LW-1], shown_level};
  assign mag       = gap[LW] ? (LW+1)'(-gap) : gap;
  assign span      = {trail_level[LW-1], trail_level} - {shown_level[LW-1], shown_level};
  assign el_sum    = {1'b0, anim_elapsed} + 33'(dt);
  assign el_sat    = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
  assign lag_eff   = (trail_lag != 16'd0) ? trail_lag : DEFAULT_LAG;
  assign shown_ext = {shown_level[LW-1], shown_level};
  assign trail_ext = {trail_level[LW-1], trail_level};

  // One shared multiplier: the animation gap by the elapsed time, or the
  // trail span by the tick.
  always_comb begin
    if (state == S_EXEC) begin
      mul_a = mag;
      mul_b = el_sat[15:0];
    end else begin
      mul_a = span;
      mul_b = dt;
    end
  end
  assign mul_out = DW'(mul_a) * DW'(mul_b);

  // Divider operand selection follows the state the request is made in.
  always_comb begin
    div_ctl.go         = div_go;
    div_ctl.short_mode = (state == S_FDIV) || (state == S_RDIV);
    case (state)
      S_ADIV: begin
        div_dividend = prod;
        div_divisor  = 32'(animate_duration);
      end
      S_TDIV: begin
        div_dividend = prod;
        div_divisor  = 32'(lag_eff);
      end
      S_FDIV: begin
        div_dividend = DW'({shown_level, 16'h0000});
        div_divisor  = max_level;
      end
      S_RDIV: begin
        div_dividend = DW'({trail_level, 16'h0000});
        div_divisor  = max_level;
      end
      default: begin
        div_dividend = prod;
        div_divisor  = max_level;
      end
    endcase
  end

  lba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Ramp color, used only in the ramp style.
  always_comb begin
    color = base_color;
    if (bar_style == STYLE_RAMP) begin
      if (fr < RATIO_QUARTER && low_color != 32'd0) color = low_color;
      else if (fr < RATIO_HALF && mid_color != 32'd0) color = mid_color;
      else if (high_color != 32'd0) color = high_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_style        <= STYLE_FLAT;
      animate_duration <= '0;
      trail_lag        <= '0;
      max_level        <= 32'sd65536;
      base_color       <= '0;
      low_color        <= '0;
      mid_color        <= '0;
      high_color       <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BAR_STYLE:  bar_style        <= cfg_wdata[1:0];
        REG_ANIM_DUR:   animate_duration <= cfg_wdata[15:0];
        REG_TRAIL_LAG:  trail_lag        <= cfg_wdata[15:0];
        REG_MAX_LEVEL:  max_level        <= cfg_wdata;
        REG_BASE_COLOR: base_color       <= cfg_wdata;
        REG_LOW_COLOR:  low_color        <= cfg_wdata;
        REG_MID_COLOR:  mid_color        <= cfg_wdata;
        REG_HIGH_COLOR: high_color       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_go       <= 1'b0;
      out_valid    <= 1'b0;
      shown_level  <= '0;
      goal_level   <= '0;
      trail_level  <= '0;
      anim_elapsed <= '0;
    end else begin
      div_go <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_data.cmd;
            lvl   <= fit_level(in_data.new_level);
            dt    <= in_data.tick_ms;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd == CMD_SET) begin
            if (animate_duration != 16'd0) begin
              goal_level   <= lvl;
              anim_elapsed <= '0;
            end else begin
              shown_level <= lvl;
              goal_level  <= lvl;
              if (bar_style != STYLE_TRAIL || lvl > trail_level) begin
                trail_level <= lvl;
              end
            end
            state <= S_FR;
          end else if (dt == 16'd0) begin
            state <= S_FR;
          end else if (animate_duration != 16'd0 && gap != '0) begin
            gap_neg <= gap[LW];
            if (el_sat >= 32'(animate_duration)) begin
              shown_level  <= goal_level;
              anim_elapsed <= '0;
              state        <= S_TRAIL;
            end else begin
              anim_elapsed <= el_sat;
              prod         <= mul_out;
              div_go       <= 1'b1;
              state        <= S_ADIV;
            end
          end else begin
            state <= S_TRAIL;
          end
        end
        S_ADIV: begin
          if (div_done) begin
            shown_level <= gap_neg ? LW'(shown_ext - div_q) : LW'(shown_ext + div_q);
            state       <= S_TRAIL;
          end
        end
        S_TRAIL: begin
          if (bar_style == STYLE_TRAIL && trail_level > shown_level) begin
            if (dt >= lag_eff) begin
              trail_level <= shown_level;
              state       <= S_FR;
            end else begin
              prod   <= mul_out;
              div_go <= 1'b1;
              state  <= S_TDIV;
            end
          end else begin
            // Other styles follow the shown level; the trail style only
            // snaps up to it.
            trail_level <= shown_level;
            state       <= S_FR;
          end
        end
        S_TDIV: begin
          // The step is strictly below the span, so the trail never
          // undershoots the shown level.
          if (div_done) begin
            trail_level <= LW'(trail_ext - div_q);
            state       <= S_FR;
          end
        end
        S_FR: begin
          if (max_level <= 0 || shown_level <= 0) begin
            fr    <= '0;
            state <= S_TR;
          end else if (shown_level >= max_level) begin
            fr    <= RATIO_ONE;
            state <= S_TR;
          end else begin
            div_go <= 1'b1;
            state  <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            fr    <= div_q[16:0];
            state <= S_TR;
          end
        end
        S_TR: begin
          if (max_level <= 0 || trail_level <= 0) begin
            tr    <= '0;
            state <= S_DONE;
          end else if (trail_level >= max_level) begin
            tr    <= RATIO_ONE;
            state <= S_DONE;
          end else begin
            div_go <= 1'b1;
            state  <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            tr    <= div_q[16:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.fill_ratio  <= fr;
      out_data.trail_ratio <= tr;
      out_data.fill_color  <= color;
    end
  end

endmodule
